// ----- hdl/itoa_fmt_pkg.sv -----
// Shared types, codes and character helpers for the integer-to-ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package itoa_fmt_pkg;

    // Conversion modes carried in the request's tuser field
    localparam logic [2:0] MODE_DEC  = 3'd0;
    localparam logic [2:0] MODE_LHEX = 3'd1;
    localparam logic [2:0] MODE_UHEX = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;
    localparam logic [2:0] MODE_BIN  = 3'd4;
    localparam logic [2:0] MODE_PTR  = 3'd5;

    // Bit positions inside format_flags
    localparam int FLAG_HASH  = 0;
    localparam int FLAG_ZPAD  = 1;
    localparam int FLAG_LEFT  = 2;
    localparam int FLAG_SPACE = 3;
    localparam int FLAG_PLUS  = 4;

    // ASCII codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    // Digit store depth (one entry per binary digit of a 32-bit value)
    localparam int DIG_DEPTH = 32;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_DEC_FIX,
        ST_SETUP,
        ST_LEAD,
        ST_SIGN,
        ST_PREFIX,
        ST_ZERO,
        ST_DIGIT,
        ST_TRAIL
    } state_t;

    // Output phase selected for an emitted character
    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGIT,
        PH_TRAIL
    } phase_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic   load;
        logic   shift_step;
        logic   dec_est;
        logic   dec_fix;
        logic   setup;
        logic   emit;
        phase_t phase;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic conv_done;
        logic dec_mode;
        logic lead_zero;
        logic sign_zero;
        logic prefix_zero;
        logic zero_zero;
        logic digit_zero;
        logic trail_zero;
    } sts_t;

    // Digit value to ASCII, lower or upper case letters
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UP_A : CH_LOW_A;
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'h0, d};
        else
            digit_char = base + {4'h0, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/itoa_fmt_dp.sv -----
// Datapath: item registers, digit conversion, digit store, pad counters, output register.
`timescale 1ns / 1ps
`default_nettype none

module itoa_fmt_dp #(
    parameter int MAX_WIDTH = 48
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [31:0]         magnitude,
    input  wire                 negative,
    input  wire  [2:0]          mode,
    input  wire  [4:0]          format_flags,
    input  wire  [5:0]          field_width,
    input  wire  [6:0]          precision,
    input  wire itoa_fmt_pkg::cmd_t cmd,
    output itoa_fmt_pkg::sts_t  sts,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    // Count width: enough for max(width, digits + precision pads + sign + prefix)
    localparam int CW = $clog2(MAX_WIDTH + 36);
    localparam logic [5:0] MAXW = 6'(MAX_WIDTH);

    // Item registers
    logic [31:0] val_reg;
    logic [31:0] q_reg;
    logic        neg_reg;
    logic        dec_reg;
    logic        upper_reg;
    logic [2:0]  shift_reg;
    logic [1:0]  pfx_n_reg;
    logic [7:0]  pfx_c1_reg;
    logic [4:0]  flags_reg;
    logic [5:0]  width_reg;
    logic        given_reg;
    logic [5:0]  prec_reg;

    // Digit store, least significant digit at entry 0
    logic [3:0]  digs_reg [itoa_fmt_pkg::DIG_DEPTH];
    logic [5:0]  len_reg;

    // Phase counters
    logic [CW-1:0] lead_cnt_reg;
    logic          sign_cnt_reg;
    logic [1:0]    pfx_cnt_reg;
    logic [CW-1:0] zero_cnt_reg;
    logic [5:0]    dig_cnt_reg;
    logic [CW-1:0] trail_cnt_reg;
    logic [CW-1:0] remain_reg;

    // Output register
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;

    // Mode decode at load
    logic [2:0] ld_shift;
    logic       ld_upper;
    logic [1:0] ld_pfx_n;
    logic [7:0] ld_pfx_c1;
    logic [5:0] ld_width;
    logic [5:0] ld_prec;

    always_comb
    begin
        ld_shift  = 3'd0;
        ld_upper  = 1'b0;
        ld_pfx_n  = 2'd0;
        ld_pfx_c1 = itoa_fmt_pkg::CH_ZERO;
        unique case (mode)
            itoa_fmt_pkg::MODE_LHEX:
            begin
                ld_shift  = 3'd4;
                ld_pfx_n  = format_flags[itoa_fmt_pkg::FLAG_HASH] ? 2'd2 : 2'd0;
                ld_pfx_c1 = itoa_fmt_pkg::CH_LOW_X;
            end
            itoa_fmt_pkg::MODE_UHEX:
            begin
                ld_shift  = 3'd4;
                ld_upper  = 1'b1;
                ld_pfx_n  = format_flags[itoa_fmt_pkg::FLAG_HASH] ? 2'd2 : 2'd0;
                ld_pfx_c1 = itoa_fmt_pkg::CH_UP_X;
            end
            itoa_fmt_pkg::MODE_OCT:
            begin
                ld_shift  = 3'd3;
                ld_pfx_n  = format_flags[itoa_fmt_pkg::FLAG_HASH] ? 2'd1 : 2'd0;
            end
            itoa_fmt_pkg::MODE_BIN:
            begin
                ld_shift  = 3'd1;
                ld_pfx_n  = format_flags[itoa_fmt_pkg::FLAG_HASH] ? 2'd2 : 2'd0;
                ld_pfx_c1 = itoa_fmt_pkg::CH_LOW_B;
            end
            itoa_fmt_pkg::MODE_PTR:
            begin
                ld_shift  = 3'd4;
                ld_pfx_n  = 2'd2;
                ld_pfx_c1 = itoa_fmt_pkg::CH_LOW_X;
            end
            default:
            begin
                ld_shift  = 3'd0;
            end
        endcase
        ld_width = (field_width > MAXW) ? MAXW : field_width;
        ld_prec  = (precision[5:0] > MAXW) ? MAXW : precision[5:0];
    end

    // Radix power-of-two digit
    logic [3:0] sh_mask;
    logic [3:0] sh_digit;

    always_comb
    begin
        unique case (shift_reg)
            3'd1:    sh_mask = 4'h1;
            3'd3:    sh_mask = 4'h7;
            default: sh_mask = 4'hF;
        endcase
        sh_digit = val_reg[3:0] & sh_mask;
    end

    // Divide by ten, first half: quotient estimate by shifts and adds
    logic [31:0] q0, q1, q2, q3, q_est;

    always_comb
    begin
        q0    = (val_reg >> 1) + (val_reg >> 2);
        q1    = q0 + (q0 >> 4);
        q2    = q1 + (q1 >> 8);
        q3    = q2 + (q2 >> 16);
        q_est = q3 >> 3;
    end

    // Divide by ten, second half: remainder and one-step correction
    logic [31:0] rem;
    logic        rem_fix;
    logic [31:0] rem_adj;
    logic [3:0]  dec_digit;
    logic [31:0] dec_quot;

    always_comb
    begin
        rem       = val_reg - ((q_reg << 3) + (q_reg << 1));
        rem_fix   = rem > 32'd9;
        rem_adj   = rem - 32'd10;
        dec_digit = rem_fix ? rem_adj[3:0] : rem[3:0];
        dec_quot  = rem_fix ? q_reg + 32'd1 : q_reg;
    end

    // Pad and count arithmetic for setup
    logic          su_empty;
    logic [5:0]    su_len;
    logic [CW-1:0] su_len_w, su_prec_w, su_width_w;
    logic [CW-1:0] su_zeros_p, su_min, su_pad, su_zeros, su_spaces;
    logic          su_sign, su_zfill, su_left;

    always_comb
    begin
        su_empty   = !given_reg && (len_reg == 6'd0);
        su_len     = su_empty ? 6'd1 : len_reg;
        su_len_w   = CW'(su_len);
        su_prec_w  = CW'(prec_reg);
        su_width_w = CW'(width_reg);
        su_sign    = neg_reg || flags_reg[itoa_fmt_pkg::FLAG_PLUS]
                     || flags_reg[itoa_fmt_pkg::FLAG_SPACE];
        su_left    = flags_reg[itoa_fmt_pkg::FLAG_LEFT];
        su_zfill   = !given_reg && flags_reg[itoa_fmt_pkg::FLAG_ZPAD] && !su_left;
        su_zeros_p = (given_reg && (su_prec_w > su_len_w)) ? su_prec_w - su_len_w : '0;
        su_min     = su_len_w + su_zeros_p + CW'(pfx_n_reg) + CW'(su_sign);
        su_pad     = (su_width_w > su_min) ? su_width_w - su_min : '0;
        su_zeros   = su_zfill ? su_zeros_p + su_pad : su_zeros_p;
        su_spaces  = su_zfill ? '0 : su_pad;
    end

    // Emitted character
    logic [5:0] dig_idx;
    logic [7:0] emit_char;

    always_comb
    begin
        dig_idx = dig_cnt_reg - 6'd1;
        unique case (cmd.phase)
            itoa_fmt_pkg::PH_SIGN:
            begin
                if (neg_reg)
                    emit_char = itoa_fmt_pkg::CH_MINUS;
                else if (flags_reg[itoa_fmt_pkg::FLAG_PLUS])
                    emit_char = itoa_fmt_pkg::CH_PLUS;
                else
                    emit_char = itoa_fmt_pkg::CH_SPACE;
            end
            itoa_fmt_pkg::PH_PREFIX:
                emit_char = (pfx_cnt_reg == 2'd2) ? itoa_fmt_pkg::CH_ZERO : pfx_c1_reg;
            itoa_fmt_pkg::PH_ZERO:
                emit_char = itoa_fmt_pkg::CH_ZERO;
            itoa_fmt_pkg::PH_DIGIT:
                emit_char = itoa_fmt_pkg::digit_char(digs_reg[dig_idx[4:0]], upper_reg);
            default:
                emit_char = itoa_fmt_pkg::CH_SPACE;
        endcase
    end

    // Item registers and digit store
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg    <= magnitude;
            neg_reg    <= negative;
            dec_reg    <= (ld_shift == 3'd0);
            upper_reg  <= ld_upper;
            shift_reg  <= ld_shift;
            pfx_n_reg  <= ld_pfx_n;
            pfx_c1_reg <= ld_pfx_c1;
            flags_reg  <= format_flags;
            width_reg  <= ld_width;
            given_reg  <= !precision[6];
            prec_reg   <= ld_prec;
        end
        else if (cmd.shift_step)
        begin
            val_reg                <= val_reg >> shift_reg;
            digs_reg[len_reg[4:0]] <= sh_digit;
        end
        else if (cmd.dec_est)
        begin
            q_reg <= q_est;
        end
        else if (cmd.dec_fix)
        begin
            val_reg                <= dec_quot;
            digs_reg[len_reg[4:0]] <= dec_digit;
        end
        else if (cmd.setup && su_empty)
        begin
            digs_reg[0] <= 4'd0;
        end
    end

    // Digit count and phase counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            lead_cnt_reg  <= '0;
            sign_cnt_reg  <= 1'b0;
            pfx_cnt_reg   <= '0;
            zero_cnt_reg  <= '0;
            dig_cnt_reg   <= '0;
            trail_cnt_reg <= '0;
            remain_reg    <= '0;
        end
        else if (cmd.load)
        begin
            len_reg <= '0;
        end
        else if (cmd.shift_step || cmd.dec_fix)
        begin
            len_reg <= len_reg + 6'd1;
        end
        else if (cmd.setup)
        begin
            lead_cnt_reg  <= su_left ? '0 : su_spaces;
            trail_cnt_reg <= su_left ? su_spaces : '0;
            sign_cnt_reg  <= su_sign;
            pfx_cnt_reg   <= pfx_n_reg;
            zero_cnt_reg  <= su_zeros;
            dig_cnt_reg   <= su_len;
            remain_reg    <= su_min + su_pad;
        end
        else if (cmd.emit)
        begin
            remain_reg <= remain_reg - CW'(1);
            unique case (cmd.phase)
                itoa_fmt_pkg::PH_LEAD:   lead_cnt_reg  <= lead_cnt_reg - CW'(1);
                itoa_fmt_pkg::PH_SIGN:   sign_cnt_reg  <= 1'b0;
                itoa_fmt_pkg::PH_PREFIX: pfx_cnt_reg   <= pfx_cnt_reg - 2'd1;
                itoa_fmt_pkg::PH_ZERO:   zero_cnt_reg  <= zero_cnt_reg - CW'(1);
                itoa_fmt_pkg::PH_DIGIT:  dig_cnt_reg   <= dig_idx;
                default:                 trail_cnt_reg <= trail_cnt_reg - CW'(1);
            endcase
        end
    end

    // Output register: holds one character while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= (remain_reg == CW'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // Status to controller
    always_comb
    begin
        sts.out_free    = !out_valid_reg || m_tready;
        sts.conv_done   = (val_reg == 32'd0) || len_reg[5];
        sts.dec_mode    = dec_reg;
        sts.lead_zero   = (lead_cnt_reg == '0);
        sts.sign_zero   = !sign_cnt_reg;
        sts.prefix_zero = (pfx_cnt_reg == 2'd0);
        sts.zero_zero   = (zero_cnt_reg == '0);
        sts.digit_zero  = (dig_cnt_reg == 6'd0);
        sts.trail_zero  = (trail_cnt_reg == '0);
    end

endmodule

`default_nettype wire

// ----- hdl/itoa_fmt_ctrl.sv -----
// Controller: sequences conversion, setup and the six output phases.
`timescale 1ns / 1ps
`default_nettype none

module itoa_fmt_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire itoa_fmt_pkg::sts_t sts,
    output itoa_fmt_pkg::cmd_t  cmd
);

    itoa_fmt_pkg::state_t state_reg;
    itoa_fmt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itoa_fmt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.shift_step = 1'b0;
        cmd.dec_est    = 1'b0;
        cmd.dec_fix    = 1'b0;
        cmd.setup      = 1'b0;
        cmd.emit       = 1'b0;
        cmd.phase      = itoa_fmt_pkg::PH_LEAD;
        unique case (state_reg)
            itoa_fmt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = itoa_fmt_pkg::ST_CONV;
                end
            end
            // one digit per cycle for power-of-two radix; decimal steps through ST_CONV then ST_DEC_FIX per digit
            itoa_fmt_pkg::ST_CONV:
            begin
                if (sts.conv_done)
                    state_next = itoa_fmt_pkg::ST_SETUP;
                else if (sts.dec_mode)
                begin
                    cmd.dec_est = 1'b1;
                    state_next  = itoa_fmt_pkg::ST_DEC_FIX;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            itoa_fmt_pkg::ST_DEC_FIX:
            begin
                cmd.dec_fix = 1'b1;
                state_next  = itoa_fmt_pkg::ST_CONV;
            end
            itoa_fmt_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = itoa_fmt_pkg::ST_LEAD;
            end
            itoa_fmt_pkg::ST_LEAD:
            begin
                cmd.phase = itoa_fmt_pkg::PH_LEAD;
                if (sts.lead_zero)
                    state_next = itoa_fmt_pkg::ST_SIGN;
                else
                    cmd.emit = sts.out_free;
            end
            itoa_fmt_pkg::ST_SIGN:
            begin
                cmd.phase = itoa_fmt_pkg::PH_SIGN;
                if (sts.sign_zero)
                    state_next = itoa_fmt_pkg::ST_PREFIX;
                else
                    cmd.emit = sts.out_free;
            end
            itoa_fmt_pkg::ST_PREFIX:
            begin
                cmd.phase = itoa_fmt_pkg::PH_PREFIX;
                if (sts.prefix_zero)
                    state_next = itoa_fmt_pkg::ST_ZERO;
                else
                    cmd.emit = sts.out_free;
            end
            itoa_fmt_pkg::ST_ZERO:
            begin
                cmd.phase = itoa_fmt_pkg::PH_ZERO;
                if (sts.zero_zero)
                    state_next = itoa_fmt_pkg::ST_DIGIT;
                else
                    cmd.emit = sts.out_free;
            end
            itoa_fmt_pkg::ST_DIGIT:
            begin
                cmd.phase = itoa_fmt_pkg::PH_DIGIT;
                if (sts.digit_zero)
                    state_next = itoa_fmt_pkg::ST_TRAIL;
                else
                    cmd.emit = sts.out_free;
            end
            itoa_fmt_pkg::ST_TRAIL:
            begin
                cmd.phase = itoa_fmt_pkg::PH_TRAIL;
                if (sts.trail_zero)
                    state_next = itoa_fmt_pkg::ST_IDLE;
                else
                    cmd.emit = sts.out_free;
            end
            default:
            begin
                state_next = itoa_fmt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/integer_to_ascii_formatter_core.sv -----
// Integer-to-ASCII formatter: printf-style conversion of one number to a character stream.
//
// Request channel (s_*): one request describes one number - magnitude, sign flag, flags,
// field width and precision in s_tdata, conversion mode in s_tuser. Response channel
// (m_*): one ASCII character per transfer, m_tlast on the final character of the number.
// A number whose value is zero with precision zero and no sign, prefix or width produces
// no characters at all.
// One request is handled at a time; s_tready is high only while the block is idle.
// Steps per request: load, conversion, setup, then the six output phases in order, each
// checked once, with one character per cycle within a phase while the receiver keeps up.
// Conversion yields one digit per cycle for hex, octal and binary; for decimal each digit
// takes a shift-add quotient estimate, then a remainder correction, and a final check ends it.
// m_tvalid rises once conversion, setup and any empty phases ahead of the first
// character are through.
// Characters leave through a one-entry output register: when the receiver stalls, the
// character holds and the sequencer waits; nothing is dropped.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties the output
// register.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH = 48
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [31:0] magnitude, [32] negative, [37:33] format_flags, [43:38] field_width,
    // [50:44] precision (signed), [55:51] zero
    input  wire  [55:0] s_tdata,
    // [2:0] mode
    input  wire  [2:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] character
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    itoa_fmt_pkg::cmd_t cmd;
    itoa_fmt_pkg::sts_t sts;

    // Sequencer
    itoa_fmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Conversion and output datapath
    itoa_fmt_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .magnitude    (s_tdata[31:0]),
        .negative     (s_tdata[32]),
        .mode         (s_tuser),
        .format_flags (s_tdata[37:33]),
        .field_width  (s_tdata[43:38]),
        .precision    (s_tdata[50:44]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // A character is never written over one the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("character emitted while output register is occupied");

    // Once a request is taken the block is busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    // At most one datapath operation per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.shift_step, cmd.dec_est, cmd.dec_fix, cmd.setup, cmd.emit}))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
